FILE: rtl/evsc_pkg.sv
// Shared constants, register codes and the arctangent table of the view source coordinate block.
package evsc_pkg;

   // Configuration port layout.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAN_HALF_HFOV = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TAN_HALF_VFOV = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_YAW       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_YAW       = 3'd7;

   // Register widths.
   localparam int DIMREG_W = 13;
   localparam int TAN_W    = 20;
   localparam int TRIG_W   = 18;

   // Register reset values.
   localparam logic [DIMREG_W-1:0]      VIEW_WIDTH_RST    = 13'd640;
   localparam logic [DIMREG_W-1:0]      VIEW_HEIGHT_RST   = 13'd480;
   localparam logic [DIMREG_W-1:0]      SOURCE_WIDTH_RST  = 13'd1920;
   localparam logic [DIMREG_W-1:0]      SOURCE_HEIGHT_RST = 13'd960;
   localparam logic [TAN_W-1:0]         TAN_HFOV_RST      = 20'd65536;
   localparam logic [TAN_W-1:0]         TAN_VFOV_RST      = 20'd49152;
   localparam logic signed [TRIG_W-1:0] COS_YAW_RST       = 18'sd65536;
   localparam logic signed [TRIG_W-1:0] SIN_YAW_RST       = 18'sd0;

   // Result field widths.
   localparam int OUT_COL_W = 20;
   localparam int OUT_ROW_W = 21;

   // Default parameter values.
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int OUT_FRAC_BITS_DEF = 8;
   localparam int DIM_BITS_DEF      = 12;

   // Binary angles: one turn is 2^32.
   localparam int ANG_W     = 34;
   localparam int LON_W     = 32;
   localparam int TABLE_LEN = 24;
   localparam logic signed [ANG_W-1:0] ANGLE_QUARTER = 34'sd1073741824;
   localparam logic signed [ANG_W-1:0] ANGLE_HALF    = 34'sd2147483648;
   localparam logic [LON_W-1:0]        LON_OFFSET    = 32'h8000_0000;

   // Inverse CORDIC gain in Q16.
   localparam int GAIN_W = 17;
   localparam logic signed [GAIN_W-1:0] INV_GAIN_Q16 = 17'sd39797;

   // Arctangent of 2^-i in binary angle units.
   localparam logic signed [ANG_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81
   };

endpackage

FILE: rtl/equirect_view_source_coords_top.sv
// Top level: equirectangular panorama source coordinates for each rectilinear view pixel.
//
// The req_ channel takes one view pixel (out_col, out_row) per transfer; the rsp_ channel
// returns its panorama position (src_col, src_row), unsigned with OUT_FRAC_BITS fraction
// bits, one result per request and in request order. A transfer happens on a rising edge
// where valid is high and stall is low. The csr_ channel writes the eight registers by
// index; csr_ready is always high. Registers are to be changed only while the block is
// empty; the block itself does not enforce it. Throughput is one pixel per clock while
// req_stall is low. The ray divider is QUO_W bits wide, one quotient bit per stage (34 at
// default parameters).
// Reset empties the pipeline and loads the register defaults.
// When rsp_stall is high the result holds on the outputs while one more result moves into a
// skid register; only when that register is full does req_stall rise and the whole pipeline
// hold. No transfer is lost or repeated.
module equirect_view_source_coords_top
   import evsc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
   parameter int DIM_BITS      = DIM_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DIM_BITS-1:0]   req_out_col,
   input  logic [DIM_BITS-1:0]   req_out_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_COL_W-1:0]  rsp_src_col,
   output logic [OUT_ROW_W-1:0]  rsp_src_row,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Datapath widths.
   localparam int NUM_W  = ((DIM_BITS + 1 > DIMREG_W) ? DIM_BITS + 1 : DIMREG_W) + 2;
   localparam int MAG_W  = NUM_W - 1;
   localparam int QUO_W  = MAG_W + TAN_W;
   localparam int RX_W   = QUO_W + 1;
   localparam int PROD_W = RX_W + TRIG_W;
   localparam int ROT_W  = PROD_W - 15;
   localparam int CW     = ROT_W + 3;
   localparam int HP_W   = CW + GAIN_W;
   localparam int MAP_W  = LON_W + DIMREG_W;
   localparam int COL_SH = LON_W - OUT_FRAC_BITS;
   localparam int ROW_SH = LON_W - 1 - OUT_FRAC_BITS;

   // Configuration registers.
   logic [DIMREG_W-1:0]      view_width_ff;
   logic [DIMREG_W-1:0]      view_height_ff;
   logic [DIMREG_W-1:0]      source_width_ff;
   logic [DIMREG_W-1:0]      source_height_ff;
   logic [TAN_W-1:0]         tan_hfov_ff;
   logic [TAN_W-1:0]         tan_vfov_ff;
   logic signed [TRIG_W-1:0] cos_yaw_ff;
   logic signed [TRIG_W-1:0] sin_yaw_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff    <= VIEW_WIDTH_RST;
         view_height_ff   <= VIEW_HEIGHT_RST;
         source_width_ff  <= SOURCE_WIDTH_RST;
         source_height_ff <= SOURCE_HEIGHT_RST;
         tan_hfov_ff      <= TAN_HFOV_RST;
         tan_vfov_ff      <= TAN_VFOV_RST;
         cos_yaw_ff       <= COS_YAW_RST;
         sin_yaw_ff       <= SIN_YAW_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VIEW_WIDTH:    view_width_ff    <= csr_data[DIMREG_W-1:0];
            CSR_VIEW_HEIGHT:   view_height_ff   <= csr_data[DIMREG_W-1:0];
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_data[DIMREG_W-1:0];
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_data[DIMREG_W-1:0];
            CSR_TAN_HALF_HFOV: tan_hfov_ff      <= csr_data[TAN_W-1:0];
            CSR_TAN_HALF_VFOV: tan_vfov_ff      <= csr_data[TAN_W-1:0];
            CSR_COS_YAW:       cos_yaw_ff       <= signed'(csr_data[TRIG_W-1:0]);
            CSR_SIN_YAW:       sin_yaw_ff       <= signed'(csr_data[TRIG_W-1:0]);
            default: ;
         endcase
      end
   end

   // A zero view dimension acts as one.
   logic [DIMREG_W-1:0] vw_eff;
   logic [DIMREG_W-1:0] vh_eff;

   assign vw_eff = (view_width_ff == '0) ? DIMREG_W'(1) : view_width_ff;
   assign vh_eff = (view_height_ff == '0) ? DIMREG_W'(1) : view_height_ff;

   // The whole pipeline advances together unless the skid register is full.
   logic skid_full_ff;
   logic en;

   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // Stage 1: centered numerators 2*pos+1-dim, split into magnitude and sign.
   logic signed [NUM_W-1:0] nx;
   logic signed [NUM_W-1:0] ny;
   logic                    s1_valid_ff;
   logic [MAG_W-1:0]        s1_magx_ff;
   logic [MAG_W-1:0]        s1_magy_ff;
   logic                    s1_negx_ff;
   logic                    s1_negy_ff;

   assign nx = signed'(NUM_W'({req_out_col, 1'b1})) - signed'(NUM_W'(vw_eff));
   assign ny = signed'(NUM_W'({req_out_row, 1'b1})) - signed'(NUM_W'(vh_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_magx_ff <= MAG_W'(nx[NUM_W-1] ? -nx : nx);
         s1_magy_ff <= MAG_W'(ny[NUM_W-1] ? -ny : ny);
         s1_negx_ff <= nx[NUM_W-1];
         s1_negy_ff <= ny[NUM_W-1];
      end
   end

   // Stage 2: scale by the half field of view tangents.
   logic             s2_valid_ff;
   logic [QUO_W-1:0] s2_px_ff;
   logic [QUO_W-1:0] s2_py_ff;
   logic             s2_negx_ff;
   logic             s2_negy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_px_ff   <= QUO_W'(s1_magx_ff * tan_hfov_ff);
         s2_py_ff   <= QUO_W'(s1_magy_ff * tan_vfov_ff);
         s2_negx_ff <= s1_negx_ff;
         s2_negy_ff <= s1_negy_ff;
      end
   end

   // Divide by the view dimensions; quotients of magnitudes truncate toward zero.
   logic             divx_valid;
   logic             divy_valid;
   logic [QUO_W-1:0] divx_q;
   logic [QUO_W-1:0] divy_q;
   logic             divx_neg;
   logic             divy_neg;

   evsc_div #(
      .N_W    (QUO_W),
      .D_W    (DIMREG_W),
      .SIDE_W (1)
   ) u_div_x (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (s2_valid_ff),
      .in_dividend  (s2_px_ff),
      .in_divisor   (vw_eff),
      .in_side      (s2_negx_ff),
      .out_valid    (divx_valid),
      .out_quotient (divx_q),
      .out_side     (divx_neg)
   );

   evsc_div #(
      .N_W    (QUO_W),
      .D_W    (DIMREG_W),
      .SIDE_W (1)
   ) u_div_y (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (s2_valid_ff),
      .in_dividend  (s2_py_ff),
      .in_divisor   (vh_eff),
      .in_side      (s2_negy_ff),
      .out_valid    (divy_valid),
      .out_quotient (divy_q),
      .out_side     (divy_neg)
   );

   // Stage 3: restore the signs of the ray components.
   logic signed [RX_W-1:0] qx_s;
   logic signed [RX_W-1:0] qy_s;
   logic                   s3_valid_ff;
   logic signed [RX_W-1:0] s3_rx_ff;
   logic signed [RX_W-1:0] s3_ry_ff;

   assign qx_s = signed'({1'b0, divx_q});
   assign qy_s = signed'({1'b0, divy_q});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= divx_valid && divy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_rx_ff <= divx_neg ? -qx_s : qx_s;
         s3_ry_ff <= divy_neg ? -qy_s : qy_s;
      end
   end

   // Stage 4: yaw rotation products.
   logic                     s4_valid_ff;
   logic signed [PROD_W-1:0] s4_pcos_ff;
   logic signed [PROD_W-1:0] s4_psin_ff;
   logic signed [RX_W-1:0]   s4_ry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_pcos_ff <= PROD_W'(s3_rx_ff * cos_yaw_ff);
         s4_psin_ff <= PROD_W'(s3_rx_ff * sin_yaw_ff);
         s4_ry_ff   <= s3_ry_ff;
      end
   end

   // Stage 5: finish the rotation with floor shifts back to Q16.
   logic signed [PROD_W:0]  sum_x;
   logic signed [PROD_W:0]  sum_z;
   logic                    s5_valid_ff;
   logic signed [ROT_W-1:0] s5_rotx_ff;
   logic signed [ROT_W-1:0] s5_rotz_ff;
   logic signed [RX_W-1:0]  s5_ry_ff;

   assign sum_x = (PROD_W+1)'(s4_pcos_ff) + ((PROD_W+1)'(sin_yaw_ff) <<< 16);
   assign sum_z = ((PROD_W+1)'(cos_yaw_ff) <<< 16) - (PROD_W+1)'(s4_psin_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_rotx_ff <= ROT_W'(sum_x >>> 16);
         s5_rotz_ff <= ROT_W'(sum_z >>> 16);
         s5_ry_ff   <= s4_ry_ff;
      end
   end

   // Longitude: angle of (rot_z, rot_x); the gained magnitude feeds the latitude.
   logic                    c1_valid;
   logic signed [CW-1:0]    c1_mag;
   logic signed [ANG_W-1:0] c1_angle;
   logic [RX_W-1:0]         c1_ry;

   evsc_cordic #(
      .W      (CW),
      .STAGES (CORDIC_STAGES),
      .SIDE_W (RX_W)
   ) u_cordic_lon (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_valid_ff),
      .in_x      (CW'(s5_rotz_ff)),
      .in_y      (CW'(s5_rotx_ff)),
      .in_side   (s5_ry_ff),
      .out_valid (c1_valid),
      .out_mag   (c1_mag),
      .out_angle (c1_angle),
      .out_side  (c1_ry)
   );

   // Stage 6: remove the CORDIC gain from the horizontal magnitude.
   logic                   s6_valid_ff;
   logic signed [HP_W-1:0] s6_hprod_ff;
   logic [LON_W-1:0]       s6_lon_ff;
   logic signed [RX_W-1:0] s6_ry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= c1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_hprod_ff <= HP_W'(c1_mag * INV_GAIN_Q16);
         s6_lon_ff   <= c1_angle[LON_W-1:0];
         s6_ry_ff    <= signed'(c1_ry);
      end
   end

   // Latitude: angle of (horizontal magnitude, ry).
   logic                    c2_valid;
   logic signed [CW-1:0]    c2_mag;
   logic signed [ANG_W-1:0] c2_angle;
   logic [LON_W-1:0]        c2_lon;
   logic signed [CW-1:0]    hmag;

   assign hmag = signed'(s6_hprod_ff[CW+15:16]);

   evsc_cordic #(
      .W      (CW),
      .STAGES (CORDIC_STAGES),
      .SIDE_W (LON_W)
   ) u_cordic_lat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_valid_ff),
      .in_x      (hmag),
      .in_y      (CW'(s6_ry_ff)),
      .in_side   (s6_lon_ff),
      .out_valid (c2_valid),
      .out_mag   (c2_mag),
      .out_angle (c2_angle),
      .out_side  (c2_lon)
   );

   // Stage 8: wrap the longitude, clamp the latitude and scale both to source pixels.
   logic [LON_W-1:0]        lon_u;
   logic signed [ANG_W-1:0] lat_v;
   logic [LON_W-1:0]        lat_c;
   logic                    s8_valid_ff;
   logic [MAP_W-1:0]        s8_pcol_ff;
   logic [MAP_W-1:0]        s8_prow_ff;

   always_comb begin
      lon_u = c2_lon + LON_OFFSET;
      lat_v = c2_angle + ANGLE_QUARTER;
      if (lat_v[ANG_W-1]) begin
         lat_c = '0;
      end else if (lat_v > ANGLE_HALF) begin
         lat_c = ANGLE_HALF[LON_W-1:0];
      end else begin
         lat_c = lat_v[LON_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (en) begin
         s8_valid_ff <= c2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_pcol_ff <= MAP_W'(lon_u * source_width_ff);
         s8_prow_ff <= MAP_W'(lat_c * source_height_ff);
      end
   end

   // Truncate to the output fraction and mask to the field widths.
   logic [MAP_W-1:0]     col_sh;
   logic [MAP_W-1:0]     row_sh;
   logic [OUT_COL_W-1:0] col_res;
   logic [OUT_ROW_W-1:0] row_res;

   assign col_sh  = s8_pcol_ff >> COL_SH;
   assign row_sh  = s8_prow_ff >> ROW_SH;
   assign col_res = col_sh[OUT_COL_W-1:0];
   assign row_res = row_sh[OUT_ROW_W-1:0];

   // Output register with a skid register behind it.
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic [OUT_COL_W-1:0] rsp_col_in;
   logic [OUT_ROW_W-1:0] rsp_row_ff;
   logic [OUT_ROW_W-1:0] rsp_row_in;
   logic                 skid_full_in;
   logic [OUT_COL_W-1:0] skid_col_ff;
   logic [OUT_COL_W-1:0] skid_col_in;
   logic [OUT_ROW_W-1:0] skid_row_ff;
   logic [OUT_ROW_W-1:0] skid_row_in;
   logic                 incoming;
   logic                 out_free;

   assign incoming = en && s8_valid_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      skid_full_in = skid_full_ff;
      skid_col_in  = skid_col_ff;
      skid_row_in  = skid_row_ff;
      priority if (skid_full_ff) begin
         // The skid result moves up once the waiting result is taken.
         if (!rsp_stall) begin
            rsp_col_in   = skid_col_ff;
            rsp_row_in   = skid_row_ff;
            skid_full_in = 1'b0;
         end
      end else if (incoming) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = col_res;
            rsp_row_in   = row_res;
         end else begin
            skid_full_in = 1'b1;
            skid_col_in  = col_res;
            skid_row_in  = row_res;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      skid_col_ff <= skid_col_in;
      skid_row_ff <= skid_row_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_src_col = rsp_col_ff;
   assign rsp_src_row = rsp_row_ff;

   // The latitude magnitude is not needed; keep its sign bit as a sanity signal for checks.
   logic lat_mag_neg;
   assign lat_mag_neg = c2_mag[CW-1];

`ifndef NO_ASSERTIONS
   // A full skid register always sits behind a result on the outputs.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid register full without a result on the outputs");

   // The skid register fills only after the receiver stalled a waiting result.
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled result");

   // A held pipeline keeps its last stage unchanged.
   a_hold_last_stage: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s8_valid_ff))
      else $error("pipeline moved while held");

   // The latitude CORDIC sees a nonnegative x, so its magnitude stays nonnegative.
   a_lat_mag_sign: assert property (@(posedge clock) disable iff (reset)
      c2_valid |-> !lat_mag_neg)
      else $error("latitude magnitude went negative");
`endif

endmodule

FILE: rtl/evsc_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module evsc_div
   import evsc_pkg::*;
#(
   parameter int N_W    = 34,
   parameter int D_W    = 13,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [N_W-1:0]    in_dividend,
   input  logic [D_W-1:0]    in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [N_W-1:0]    out_quotient,
   output logic [SIDE_W-1:0] out_side
);

   // Stage k holds the partial remainder and a word that trades dividend bits for quotient bits.
   logic              valid_ff [0:N_W];
   logic [D_W-1:0]    rem_ff   [0:N_W];
   logic [N_W-1:0]    work_ff  [0:N_W];
   logic [SIDE_W-1:0] side_ff  [0:N_W];

   // Entry stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         work_ff[0] <= in_dividend;
         side_ff[0] <= in_side;
      end
   end

   // One trial subtraction per stage.
   for (genvar k = 0; k < N_W; k++) begin : g_stage
      logic [D_W:0]   trial;
      logic           q_bit;
      logic [D_W-1:0] rem_in;
      logic [N_W-1:0] work_in;

      always_comb begin
         trial = {rem_ff[k], work_ff[k][N_W-1]};
         q_bit = (trial >= {1'b0, in_divisor});
         if (q_bit) begin
            rem_in = D_W'(trial - {1'b0, in_divisor});
         end else begin
            rem_in = trial[D_W-1:0];
         end
         work_in = {work_ff[k][N_W-2:0], q_bit};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            work_ff[k+1] <= work_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid    = valid_ff[N_W];
   assign out_quotient = work_ff[N_W];
   assign out_side     = side_ff[N_W];

endmodule

FILE: rtl/evsc_cordic.sv
// Pipelined vectoring CORDIC: angle and gained magnitude of a vector, one iteration per stage.
module evsc_cordic
   import evsc_pkg::*;
#(
   parameter int W      = 41,
   parameter int STAGES = CORDIC_STAGES_DEF,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [W-1:0]     in_x,
   input  logic signed [W-1:0]     in_y,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic signed [W-1:0]     out_mag,
   output logic signed [ANG_W-1:0] out_angle,
   output logic [SIDE_W-1:0]       out_side
);

   logic                    valid_ff [0:STAGES];
   logic                    zero_ff  [0:STAGES];
   logic signed [W-1:0]     x_ff     [0:STAGES];
   logic signed [W-1:0]     y_ff     [0:STAGES];
   logic signed [ANG_W-1:0] z_ff     [0:STAGES];
   logic [SIDE_W-1:0]       side_ff  [0:STAGES];

   logic                    zero_in;
   logic signed [W-1:0]     x0_in;
   logic signed [W-1:0]     y0_in;
   logic signed [ANG_W-1:0] z0_in;

   // Turn a left half plane vector by a quarter turn so the iterations converge.
   always_comb begin
      zero_in = (in_x == '0) && (in_y == '0);
      x0_in   = in_x;
      y0_in   = in_y;
      z0_in   = '0;
      if (in_x[W-1]) begin
         if (!in_y[W-1]) begin
            x0_in = in_y;
            y0_in = -in_x;
            z0_in = ANGLE_QUARTER;
         end else begin
            x0_in = -in_y;
            y0_in = in_x;
            z0_in = -ANGLE_QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= zero_in;
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         side_ff[0] <= in_side;
      end
   end

   // Micro-rotations with floor shifts, driving y toward zero.
   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      logic signed [W-1:0]     xs;
      logic signed [W-1:0]     ys;
      logic signed [W-1:0]     x_in;
      logic signed [W-1:0]     y_in;
      logic signed [ANG_W-1:0] z_in;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         if (!y_ff[i][W-1]) begin
            x_in = x_ff[i] + ys;
            y_in = y_ff[i] - xs;
            z_in = z_ff[i] + ATAN_TABLE[i];
         end else begin
            x_in = x_ff[i] - ys;
            y_in = y_ff[i] + xs;
            z_in = z_ff[i] - ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // A zero vector reports angle zero and magnitude zero.
   assign out_valid = valid_ff[STAGES];
   assign out_mag   = zero_ff[STAGES] ? '0 : x_ff[STAGES];
   assign out_angle = zero_ff[STAGES] ? '0 : z_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the equirectangular view source coordinate block.
`timescale 1ns / 100ps

module tb_top;
   import evsc_pkg::*;

   localparam int DIM_BITS = DIM_BITS_DEF;
   localparam int FRAC     = OUT_FRAC_BITS_DEF;
   localparam int STAGES   = CORDIC_STAGES_DEF;
   localparam int LATENCY  = 76;

   typedef struct packed {
      logic [DIM_BITS-1:0] col;
      logic [DIM_BITS-1:0] row;
   } pixel_type;

   typedef struct packed {
      logic [OUT_COL_W-1:0] src_col;
      logic [OUT_ROW_W-1:0] src_row;
   } coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [DIM_BITS-1:0] req_out_col = '0;
   logic [DIM_BITS-1:0] req_out_row = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_COL_W-1:0] rsp_src_col;
   logic [OUT_ROW_W-1:0] rsp_src_row;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the register file used by the coordinate predictor.
   logic [12:0] vw_reg, vh_reg, sw_reg, sh_reg;
   logic [19:0] th_reg, tv_reg;
   logic signed [17:0] cy_reg, sy_reg;

   pixel_type pixel_queue[$];
   coord_type coord_queue[$];
   int        errors = 0;
   int        hold_cycles = 0;
   bit        driving = 1'b0;
   int        send_gap = 0;
   int        recv_gap = 0;

   equirect_view_source_coords_top dut (.*);

   always #10 clock = ~clock;

   // Floor division by a power of two.
   function automatic longint floor_sh(longint v, int s);
      return v >>> s;
   endfunction

   // Vectoring CORDIC in binary-angle units; returns the angle, mag gets gained x.
   function automatic longint vec_angle(longint x, longint y, output longint mag);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return 0;
      end
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = ANGLE_QUARTER;
         end else begin
            t = x; x = -y; y = t; z = -ANGLE_QUARTER;
         end
      end
      for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
         xs = floor_sh(x, i);
         ys = floor_sh(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z += ATAN_TABLE[i];
         end else begin
            x = x - ys; y = y + xs; z -= ATAN_TABLE[i];
         end
      end
      mag = x;
      return z;
   endfunction

   // Predicted panorama position of one view pixel.
   function automatic coord_type source_position(pixel_type p);
      longint vw, vh, rx, ry, rot_x, rot_z, gmag, hmag, dummy, lon, lat, v;
      logic [63:0] u, sc, sr;
      coord_type c;
      vw = (vw_reg == 0) ? 1 : longint'(vw_reg);
      vh = (vh_reg == 0) ? 1 : longint'(vh_reg);
      rx = ((2 * longint'(p.col) + 1 - vw) * longint'(th_reg)) / vw;
      ry = ((2 * longint'(p.row) + 1 - vh) * longint'(tv_reg)) / vh;
      rot_x = floor_sh(longint'(cy_reg) * rx + longint'(sy_reg) * 65536, 16);
      rot_z = floor_sh(longint'(cy_reg) * 65536 - longint'(sy_reg) * rx, 16);
      lon = vec_angle(rot_z, rot_x, gmag);
      hmag = (gmag * longint'(INV_GAIN_Q16)) >>> 16;
      lat = vec_angle(hmag, ry, dummy);
      u = (lon + ANGLE_HALF) & 64'hFFFF_FFFF;
      sc = (u * sw_reg) >> (32 - FRAC);
      v = lat + ANGLE_QUARTER;
      if (v < 0) v = 0;
      if (v > ANGLE_HALF) v = ANGLE_HALF;
      sr = (64'(v) * sh_reg) >> (31 - FRAC);
      c.src_col = sc[OUT_COL_W-1:0];
      c.src_row = sr[OUT_ROW_W-1:0];
      return c;
   endfunction

   // Write one register and update the shadow copy.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VIEW_WIDTH:    vw_reg = val[12:0];
         CSR_VIEW_HEIGHT:   vh_reg = val[12:0];
         CSR_SOURCE_WIDTH:  sw_reg = val[12:0];
         CSR_SOURCE_HEIGHT: sh_reg = val[12:0];
         CSR_TAN_HALF_HFOV: th_reg = val;
         CSR_TAN_HALF_VFOV: tv_reg = val;
         CSR_COS_YAW:       cy_reg = val[17:0];
         CSR_SIN_YAW:       sy_reg = val[17:0];
         default: ;
      endcase
   endtask

   // Push a whole setting of all eight registers.
   task automatic load_setting(int vw, int vh, int sw, int sh, int th, int tv, int cy, int sy);
      write_reg(CSR_VIEW_WIDTH, CSR_DATA_W'(vw));
      write_reg(CSR_VIEW_HEIGHT, CSR_DATA_W'(vh));
      write_reg(CSR_SOURCE_WIDTH, CSR_DATA_W'(sw));
      write_reg(CSR_SOURCE_HEIGHT, CSR_DATA_W'(sh));
      write_reg(CSR_TAN_HALF_HFOV, CSR_DATA_W'(th));
      write_reg(CSR_TAN_HALF_VFOV, CSR_DATA_W'(tv));
      write_reg(CSR_COS_YAW, CSR_DATA_W'(cy));
      write_reg(CSR_SIN_YAW, CSR_DATA_W'(sy));
   endtask

   // Send pixels and wait until the block has drained them.
   task automatic run_phase(int count, bit directed);
      pixel_type p;
      for (int i = 0; i < count; i++) begin
         if (directed) begin
            case (i % 6)
               0: p = '{col: '0, row: '0};
               1: p = '{col: '1, row: '1};
               2: p = '{col: '0, row: '1};
               3: p = '{col: '1, row: '0};
               4: p = '{col: DIM_BITS'(vw_reg >> 1), row: DIM_BITS'(vh_reg >> 1)};
               default: p = '{col: 12'hAAA, row: 12'h555};
            endcase
         end else if ($urandom_range(0, 3) == 0) begin
            p = '{col: DIM_BITS'($urandom), row: DIM_BITS'($urandom)};
         end else begin
            p.col = DIM_BITS'($urandom_range(0, (vw_reg == 0) ? 0 : vw_reg - 1));
            p.row = DIM_BITS'($urandom_range(0, (vh_reg == 0) ? 0 : vh_reg - 1));
         end
         pixel_queue.push_back(p);
      end
      while (pixel_queue.size() != 0 || driving || coord_queue.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Driver: one pixel transfer at a time, in bursts with a random gap before each burst.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         coord_queue.push_back(source_position('{col: req_out_col, row: req_out_row}));
         if (pixel_queue.size() != 0 && $urandom_range(0, 3) == 0) begin
            req_out_col <= pixel_queue[0].col;
            req_out_row <= pixel_queue[0].row;
            void'(pixel_queue.pop_front());
         end else begin
            req_valid <= 1'b0;
            driving = 1'b0;
            send_gap = $urandom_range(0, 19);
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pixel_queue.size() != 0) begin
            req_valid <= 1'b1;
            driving = 1'b1;
            req_out_col <= pixel_queue[0].col;
            req_out_row <= pixel_queue[0].row;
            void'(pixel_queue.pop_front());
         end
      end
   end

   // Monitor: compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      coord_type exp_c;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (coord_queue.size() == 0) begin
            $error("unexpected result src_col=%0d src_row=%0d", rsp_src_col, rsp_src_row);
            errors++;
         end else begin
            exp_c = coord_queue.pop_front();
            if (rsp_src_col !== exp_c.src_col) begin
               $error("src_col expected %0d actual %0d", exp_c.src_col, rsp_src_col);
               errors++;
            end
            if (rsp_src_row !== exp_c.src_row) begin
               $error("src_row expected %0d actual %0d", exp_c.src_row, rsp_src_row);
               errors++;
            end
         end
      end
   end

   // Receiver stall: random per result, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         recv_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
         rsp_stall <= (recv_gap != 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Main sequence: reset, settings, directed and random phases.
   initial begin
      vw_reg = VIEW_WIDTH_RST;   vh_reg = VIEW_HEIGHT_RST;
      sw_reg = SOURCE_WIDTH_RST; sh_reg = SOURCE_HEIGHT_RST;
      th_reg = TAN_HFOV_RST;     tv_reg = TAN_VFOV_RST;
      cy_reg = COS_YAW_RST;      sy_reg = SIN_YAW_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults first.
      run_phase(12, 1'b1);
      // Extremes: zero view sizes, maximal sizes and tangents, half-turn yaw.
      load_setting(0, 0, 8191, 8191, 1048575, 1048575, -65536, 0);
      run_phase(6, 1'b1);
      load_setting(4096, 4096, 4096, 4096, 524288, 524288, 0, 65536);
      run_phase(6, 1'b1);
      // Register values past the legal range, used as written.
      load_setting(8191, 1, 1, 0, 0, 0, -131072, 131071);
      run_phase(6, 1'b1);

      // Random settings with mostly in-view pixels; long hold-off in one phase.
      for (int ph = 0; ph < 8; ph++) begin
         load_setting($urandom_range(1, 4096), $urandom_range(1, 4096),
                      $urandom_range(1, 4096), $urandom_range(1, 4096),
                      $urandom_range(0, 524288), $urandom_range(0, 524288),
                      $signed($urandom_range(0, 131072)) - 65536,
                      $signed($urandom_range(0, 131072)) - 65536);
         if (ph == 3) hold_cycles = 400;
         run_phase(125, 1'b0);
      end

      if (errors == 0)
         $display("** equirect_view_source_coords_top: PASSED **");
      else
         $display("** equirect_view_source_coords_top: FAILED **");
      $finish;
   end

   // Run limit.
   initial begin
      #(20 * 400000);
      $display("** equirect_view_source_coords_top: FAILED **");
      $finish;
   end

endmodule
